// ===== hw/rtl/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg
// Shared constants for the reed pulse speedometer.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

  localparam int unsigned CIRC_W   = 10;
  localparam int unsigned TOUT_W   = 16;
  localparam int unsigned SPEED_W  = 10;
  localparam int unsigned BAR_W    = 3;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [CIRC_W-1:0]  CIRC_RST   = CIRC_W'(100);
  localparam logic [TOUT_W-1:0]  TOUT_RST   = TOUT_W'(3600);
  localparam logic [SPEED_W-1:0] SPEED_MAX  = SPEED_W'(1023);
  localparam int unsigned        PERIOD_DIV = 36;

  // period / 36 at or past this exceeds any circumference, so speed is 0
  localparam int unsigned PERIOD_LONG = PERIOD_DIV * (1 << CIRC_W);

  // period / 36 = (period / 4) / 9, the / 9 by reciprocal multiply
  localparam int unsigned        QTR_W    = 14;
  localparam int unsigned        RECIP_W  = 13;
  localparam logic [RECIP_W-1:0] RECIP9   = RECIP_W'(7282);  // ceil(2^16 / 9)
  localparam int unsigned        RECIP_SH = 16;

  // register index, taken from paddr[2]
  localparam logic REG_CIRC = 1'b0;
  localparam logic REG_TOUT = 1'b1;

  // bar thresholds on speed (twice speed up to 10, 20, 30)
  localparam logic [SPEED_W-1:0] BAR_T1 = SPEED_W'(5);
  localparam logic [SPEED_W-1:0] BAR_T2 = SPEED_W'(10);
  localparam logic [SPEED_W-1:0] BAR_T3 = SPEED_W'(15);

  localparam logic [BAR_W-1:0] BAR_OFF = BAR_W'(0);
  localparam logic [BAR_W-1:0] BAR_1   = BAR_W'(1);
  localparam logic [BAR_W-1:0] BAR_2   = BAR_W'(2);
  localparam logic [BAR_W-1:0] BAR_3   = BAR_W'(3);
  localparam logic [BAR_W-1:0] BAR_4   = BAR_W'(4);

endpackage

`default_nettype wire

// ===== hw/rtl/rps_divider.sv =====
// ----------------------------------------------------------------------------
// rps_divider
// Restoring radix-2 divider, one quotient bit per cycle over all W dividend
// bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_divider #(
  parameter int unsigned W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [W-1:0]      dividend_i,
  input  wire logic [W-1:0]      divisor_i,
  output logic                   done_o,
  output logic [W-1:0]           quotient_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     dvd_q, dvd_d;
  logic [W-1:0]     dsr_q, dsr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       ge;

  assign shifted = {rem_q, dvd_q[W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign ge      = shifted >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (run_q) begin
      rem_d = ge ? diff[W-1:0] : shifted[W-1:0];
      dvd_d = {dvd_q[W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      rem_d = '0;
      dvd_d = dividend_i;
      dsr_d = divisor_i;
      cnt_d = CNT_W'(W);
      run_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/reed_pulse_speedometer.sv =====
// Path: accept, emit state, result word when no speed is computed; the
//   period check before emit when it fixes the speed; check and divider else.
// Throughput: one sample at a time; the next is taken as its result is
//   offered, which a stalled result holds back.
// Reset: asynchronous, active low; control state and totals clear, registers
//   return to circumference 100 cm and timeout 3600 ms.
// ----------------------------------------------------------------------------
// reed_pulse_speedometer
// Reed switch speedometer: timeout check, edge detect, speed by iterative
// division, wrapping time and distance totals, bar level output.
// ----------------------------------------------------------------------------
`default_nettype none

module reed_pulse_speedometer #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // APB config
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rps_pkg::APB_AW-1:0]      paddr,
  input  wire logic [rps_pkg::APB_DW-1:0]      pwdata,
  output logic [rps_pkg::APB_DW-1:0]           prdata,
  output logic                                 pready,
  // sample in
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [TIME_WIDTH-1:0]           now_ms_i,
  input  wire logic                            reed_raw_i,
  // result out
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [rps_pkg::SPEED_W-1:0]          speed_kmh_o,
  output logic [rps_pkg::BAR_W-1:0]            bar_level_o,
  output logic                                 moving_o,
  output logic                                 pulse_active_o,
  output logic [rps_pkg::TOTAL_W-1:0]          total_time_ms_o,
  output logic [rps_pkg::TOTAL_W-1:0]          total_distance_cm_o
);

  localparam int unsigned W = TIME_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVP = 2'd1;
  localparam logic [1:0] ST_DIVC = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  // --------------------------------------------------------------------------
  // config registers
  logic [rps_pkg::CIRC_W-1:0] circ_q;
  logic [rps_pkg::TOUT_W-1:0] tout_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q <= rps_pkg::CIRC_RST;
      tout_q <= rps_pkg::TOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == rps_pkg::REG_CIRC) begin
        circ_q <= pwdata[rps_pkg::CIRC_W-1:0];
      end else begin
        tout_q <= pwdata[rps_pkg::TOUT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rps_pkg::REG_TOUT) begin
      prdata = {{(rps_pkg::APB_DW - rps_pkg::TOUT_W){1'b0}}, tout_q};
    end else begin
      prdata = {{(rps_pkg::APB_DW - rps_pkg::CIRC_W){1'b0}}, circ_q};
    end
  end

  // --------------------------------------------------------------------------
  // state
  logic [1:0]                  state_q;
  logic                        prev_q;
  logic [W-1:0]                last_q;
  logic                        moving_q;
  logic [rps_pkg::SPEED_W-1:0] speed_q;
  logic [rps_pkg::TOTAL_W-1:0] ttot_q;
  logic [rps_pkg::TOTAL_W-1:0] dtot_q;
  logic [W-1:0]                now_q;
  logic [W-1:0]                period_q;
  logic                        pulse_q;

  logic                        out_valid_q;
  logic [rps_pkg::SPEED_W-1:0] out_speed_q;
  logic [rps_pkg::BAR_W-1:0]   out_bar_q;
  logic                        out_moving_q;
  logic                        out_pulse_q;
  logic [rps_pkg::TOTAL_W-1:0] out_ttot_q;
  logic [rps_pkg::TOTAL_W-1:0] out_dtot_q;

  // --------------------------------------------------------------------------
  // sample front end
  logic                   in_acc;
  logic [W+15:0]          tout_wide;
  logic [W-1:0]           deadline;
  logic                   expired;
  logic                   active;
  logic                   edge_on;
  logic                   mov_t;
  logic [W-1:0]           period;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign tout_wide = {W'(0), tout_q};
  assign deadline  = last_q + tout_wide[W-1:0];
  assign expired   = deadline < now_ms_i;
  assign active    = ~reed_raw_i;
  assign edge_on   = active & ~prev_q;
  assign mov_t     = moving_q & ~expired;
  assign period    = now_ms_i - last_q;

  // --------------------------------------------------------------------------
  // period / 36; only needed below PERIOD_LONG, where period / 4 fits QTR_W
  logic                                        period_long;
  logic [rps_pkg::QTR_W-1:0]                   period_qtr;
  logic [rps_pkg::QTR_W+rps_pkg::RECIP_W-1:0]  div36_prod;
  logic [rps_pkg::CIRC_W-1:0]                  div36;

  assign period_long = period_q >= W'(rps_pkg::PERIOD_LONG);
  assign period_qtr  = period_q[rps_pkg::QTR_W+1:2];
  assign div36_prod  = period_qtr * rps_pkg::RECIP9;
  assign div36       = div36_prod[rps_pkg::RECIP_SH +: rps_pkg::CIRC_W];

  // --------------------------------------------------------------------------
  // shared divider: circumference / (period / 36)
  logic                       div_start;
  logic                       div_done;
  logic [rps_pkg::CIRC_W-1:0] div_quot;

  assign div_start = (state_q == ST_DIVP) & ~period_long & (div36 != '0);

  rps_divider #(
    .W (rps_pkg::CIRC_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (circ_q),
    .divisor_i  (div36),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // --------------------------------------------------------------------------
  // totals on a counted revolution
  logic [W+31:0]               period_wide;
  logic [rps_pkg::TOTAL_W-1:0] ttot_add;
  logic [rps_pkg::TOTAL_W-1:0] dtot_add;

  assign period_wide = {32'b0, period_q};
  assign ttot_add    = ttot_q + period_wide[rps_pkg::TOTAL_W-1:0];
  assign dtot_add    = dtot_q + {{(rps_pkg::TOTAL_W - rps_pkg::CIRC_W){1'b0}}, circ_q};

  // --------------------------------------------------------------------------
  // output stage
  logic                      slot_free;
  logic [rps_pkg::BAR_W-1:0] bar;

  assign slot_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    priority if (speed_q == '0) begin
      bar = rps_pkg::BAR_OFF;
    end else if (speed_q <= rps_pkg::BAR_T1) begin
      bar = rps_pkg::BAR_1;
    end else if (speed_q <= rps_pkg::BAR_T2) begin
      bar = rps_pkg::BAR_2;
    end else if (speed_q <= rps_pkg::BAR_T3) begin
      bar = rps_pkg::BAR_3;
    end else begin
      bar = rps_pkg::BAR_4;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= 1'b0;
      last_q      <= '0;
      moving_q    <= 1'b0;
      speed_q     <= '0;
      ttot_q      <= '0;
      dtot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            prev_q   <= active;
            moving_q <= mov_t | edge_on;
            speed_q  <= expired ? '0 : speed_q;
            if (edge_on && !mov_t) begin
              last_q <= now_ms_i;  // first edge only arms
            end
            state_q <= (edge_on && mov_t) ? ST_DIVP : ST_EMIT;
          end
        end
        ST_DIVP: begin
          priority if (period_long) begin
            // divisor larger than any circumference
            speed_q <= '0;
            ttot_q  <= ttot_add;
            dtot_q  <= dtot_add;
            last_q  <= now_q;
            state_q <= ST_EMIT;
          end else if (div36 == '0) begin
            // period below 36 ms
            speed_q <= rps_pkg::SPEED_MAX;
            ttot_q  <= ttot_add;
            dtot_q  <= dtot_add;
            last_q  <= now_q;
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_DIVC;
          end
        end
        ST_DIVC: begin
          if (div_done) begin
            // quotient never exceeds the circumference, so it fits
            speed_q <= div_quot[rps_pkg::SPEED_W-1:0];
            ttot_q  <= ttot_add;
            dtot_q  <= dtot_add;
            last_q  <= now_q;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (state_q == ST_EMIT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q    <= now_ms_i;
      period_q <= period;
      pulse_q  <= active;
    end
    if (state_q == ST_EMIT && slot_free) begin
      out_speed_q  <= speed_q;
      out_bar_q    <= bar;
      out_moving_q <= moving_q;
      out_pulse_q  <= pulse_q;
      out_ttot_q   <= ttot_q;
      out_dtot_q   <= dtot_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign speed_kmh_o         = out_speed_q;
  assign bar_level_o         = out_bar_q;
  assign moving_o            = out_moving_q;
  assign pulse_active_o      = out_pulse_q;
  assign total_time_ms_o     = out_ttot_q;
  assign total_distance_cm_o = out_dtot_q;

endmodule

`default_nettype wire
